FILE: design/pvt_pkg.sv
package pvt_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_SELECT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SHIFT  = 3'd3,
    OP_INSIDE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD,
    S_WAIT,
    S_EVAL,
    S_MUL,
    S_CMP,
    S_WR,
    S_DONE
  } state_t;

  localparam int unsigned RADIUS_RESET = 10;
  localparam logic [1:0]  ADDR_PICK_RADIUS = 2'd0;

endpackage

FILE: design/polygon_vertex_table_inside_test_top.sv
// Polygon vertex table with cursor and crossing-number point test.
// Input channel s_axis: one word per operation (insert, select, delete,
// translate, inside test, clear) with a point or offset. Output channel
// m_axis: exactly one result word per operation.
// APB port: register 0 at address 0 is pick_radius (8 bits, reset 10).
// Clear, unused codes and empty-table cases finish without walking the store;
// insert moves each vertex at or above the cursor up; translate rewrites
// every vertex; select searches the vertices in order; delete searches,
// then moves each vertex above the found one down; the inside test walks
// every edge, with an extra multiply step when the edge needs the shared
// multiplier. One item is worked at a time and s_axis_tready is low
// meanwhile.
// Reset clears the vertex count and the cursor and sets pick_radius to 10;
// the store is not cleared, only entries below the count are read.
// When the receiver stalls, the result is held in the output register and
// the next item is taken only after it has been accepted.
module polygon_vertex_table_inside_test_top
  import pvt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // operation[2:0], x[18:3], y[34:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status[1:0], inside_res[2], vertex_index[8:3],
                                      // vertex_count[15:9]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 2;
  localparam int PW = 2 * DW;

  state_t state, state_next;

  logic [7:0]  pick_radius;
  logic [2:0]  op;
  logic signed [COORD_BITS-1:0] px, py;
  logic [CW-1:0] total, cursor;
  logic [CW-1:0] i, pos, fidx;
  logic [1:0]  phase;
  logic        hits, first_ok;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1, sx0, sy0;
  logic signed [PW-1:0] prod, lhs;
  logic signed [DW-1:0] ma, mb;
  logic        mul_sel;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [2*COORD_BITS-1:0] wdata, rdata;
  logic signed [COORD_BITS-1:0] rx, ry;

  logic [1:0] status;
  logic       inside_r;
  logic [5:0] vidx;

  pvt_mem #(.DEPTH(MAX_VERTICES), .WIDTH(2*COORD_BITS)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  assign rx = rdata[COORD_BITS-1:0];
  assign ry = rdata[2*COORD_BITS-1:COORD_BITS];

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PICK_RADIUS) ? {24'd0, pick_radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_radius <= 8'(RADIUS_RESET);
    end else if (psel && penable && pwrite && paddr == ADDR_PICK_RADIUS) begin
      pick_radius <= pwdata[7:0];
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  // window test and quadrant logic
  logic signed [COORD_BITS+1:0] dxv, dyv, rr;
  logic near;
  assign rr  = (COORD_BITS+2)'(pick_radius);
  assign dxv = (COORD_BITS+2)'(rx) - (COORD_BITS+2)'(px);
  assign dyv = (COORD_BITS+2)'(ry) - (COORD_BITS+2)'(py);
  assign near = (dxv <= rr) && (dxv >= -rr) && (dyv <= rr) && (dyv >= -rr);

  logic [1:0] q0, q1;
  logic diag, right_pair, skip;
  assign q0 = {y0 >= py, x0 >= px};
  assign q1 = {y1 >= py, x1 >= px};
  assign skip = (y0 == y1) && (py == y0);
  assign diag = (q0 == 2'd0 && q1 == 2'd3) || (q0 == 2'd3 && q1 == 2'd0) ||
                (q0 == 2'd1 && q1 == 2'd2) || (q0 == 2'd2 && q1 == 2'd1);
  assign right_pair = (q0 == 2'd1 && q1 == 2'd3) || (q0 == 2'd3 && q1 == 2'd1);

  logic signed [DW-1:0] dy;
  assign dy = DW'(y1) - DW'(y0);

  // phase[0] marks an edge that does not count, phase[1] the closing edge
  logic flip;
  assign flip = !phase[0] && !skip &&
                ((diag && ((dy > 0 && lhs >= prod) || (dy < 0 && lhs <= prod))) ||
                 right_pair);

  // shared multiplier operands
  always_comb begin
    if (!mul_sel) begin
      ma = DW'(py) - DW'(y0);
      mb = DW'(x1) - DW'(x0);
    end else begin
      ma = DW'(px) - DW'(x0);
      mb = dy;
    end
  end

  logic [CW-1:0] last;
  assign last = total - CW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (s_axis_tvalid && s_axis_tready) state_next = S_DISPATCH;
      S_DISPATCH: begin
        state_next = S_RD;
        priority case (op)
          OP_INSERT: if (total >= CW'(MAX_VERTICES)) state_next = S_DONE;
          OP_SELECT, OP_DELETE, OP_SHIFT: if (total == '0) state_next = S_DONE;
          OP_INSIDE: if (total < CW'(2)) state_next = S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_RD: begin
        state_next = S_WAIT;
        if (op == OP_INSERT && i == pos) begin
          state_next = S_WR;
        end else if (op == OP_DELETE && phase == 2'd1 && i + CW'(1) >= total) begin
          state_next = S_DONE;
        end
      end
      S_WAIT:     state_next = S_EVAL;
      S_EVAL: begin
        state_next = S_RD;
        priority case (op)
          OP_INSERT, OP_SHIFT: state_next = S_WR;
          OP_SELECT, OP_DELETE: begin
            if (phase == 2'd1) begin
              state_next = S_WR;
            end else if (near) begin
              if (op == OP_SELECT) state_next = S_DONE;
            end else if (i == last) begin
              state_next = S_DONE;
            end
          end
          default: if (first_ok) state_next = S_MUL;
        endcase
      end
      S_MUL:      state_next = (!mul_sel && (diag || right_pair) && !skip) ? S_MUL : S_CMP;
      S_CMP: begin
        if (phase[1]) state_next = S_DONE;
        else if (i == last) state_next = S_MUL;
        else state_next = S_RD;
      end
      S_WR: begin
        state_next = S_RD;
        if (op == OP_INSERT) begin
          if (phase == 2'd3) state_next = S_DONE;
        end else if (op != OP_DELETE && i == last) begin
          state_next = S_DONE;
        end
      end
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i[AW-1:0];
    wdata = {y0, x0};
    raddr = i[AW-1:0];
    if (state == S_WR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total         <= '0;
      cursor        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[2:0];
            px <= COORD_BITS'(signed'(s_axis_tdata[18:3]));
            py <= COORD_BITS'(signed'(s_axis_tdata[34:19]));
          end
          if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        S_DISPATCH: begin
          inside_r <= 1'b0; vidx <= '0;
          hits <= 1'b0; phase <= '0; mul_sel <= 1'b0; first_ok <= 1'b0;
          priority case (op)
            OP_INSERT: begin
              i <= total;
              if (total >= CW'(MAX_VERTICES)) begin
                status <= ST_FULL;
              end else begin
                status <= ST_OK;
                pos <= (cursor > total) ? total : cursor;
              end
            end
            OP_SELECT, OP_DELETE: begin
              i <= '0;
              status <= (total == '0) ? ST_MISS : ST_OK;
            end
            OP_CLEAR: begin
              i <= '0; status <= ST_OK;
              total <= '0; cursor <= '0;
            end
            default: begin
              i <= '0; status <= ST_OK;
            end
          endcase
        end
        S_RD: begin
          // insert copies entry i-1 up to i; delete copies i+1 down to i
          priority case (op)
            OP_INSERT: if (i == pos) begin
              x0 <= px; y0 <= py; phase <= 2'd3;
            end else begin
              i <= i - CW'(1);
            end
            OP_DELETE: if (phase == 2'd1) begin
              if (i + CW'(1) >= total) begin
                total <= total - CW'(1);
                if (fidx < cursor) cursor <= cursor - CW'(1);
              end else begin
                i <= i + CW'(1);
              end
            end
            default: ;
          endcase
        end
        S_WAIT: ;
        S_EVAL: begin
          priority case (op)
            OP_INSERT: begin
              x0 <= rx; y0 <= ry; i <= i + CW'(1); phase <= 2'd2;
            end
            OP_SELECT, OP_DELETE: begin
              if (phase == 2'd1) begin
                x0 <= rx; y0 <= ry; i <= i - CW'(1);
              end else if (near) begin
                fidx <= i; vidx <= 6'(i);
                if (op == OP_SELECT) begin
                  cursor <= i + CW'(1);
                end else phase <= 2'd1;
              end else if (i == last) begin
                status <= ST_MISS;
              end else i <= i + CW'(1);
            end
            OP_SHIFT: begin
              x0 <= rx + px; y0 <= ry + py;
            end
            default: begin
              // inside test: edge from (x0,y0) to (x1,y1)
              if (!first_ok) begin
                sx0 <= rx; sy0 <= ry; x1 <= rx; y1 <= ry; first_ok <= 1'b1;
                i <= i + CW'(1);
              end else begin
                x0 <= x1; y0 <= y1; x1 <= rx; y1 <= ry;
                mul_sel <= 1'b0;
              end
            end
          endcase
        end
        S_MUL: begin
          // evaluate edge (x0,y0)->(x1,y1)
          if (!mul_sel) begin
            mul_sel <= 1'b1;
            if (skip || !(diag || right_pair)) begin
              phase[0] <= 1'b1;
            end else begin
              prod <= PW'(ma) * PW'(mb);
              phase[0] <= 1'b0;
            end
          end else begin
            lhs <= prod;
            prod <= PW'(ma) * PW'(mb);
          end
        end
        S_CMP: begin
          hits <= hits ^ flip;
          mul_sel <= 1'b0;
          if (phase[1]) begin
            inside_r <= hits ^ flip;
          end else if (i == last) begin
            x0 <= x1; y0 <= y1; x1 <= sx0; y1 <= sy0;
            phase <= 2'd2;
          end else i <= i + CW'(1);
        end
        S_WR: begin
          priority case (op)
            OP_INSERT: begin
              if (phase == 2'd3) begin
                total <= total + CW'(1);
                cursor <= pos + CW'(1);
                vidx <= 6'(pos);
              end else i <= i - CW'(1);
            end
            OP_DELETE: i <= i + CW'(1);
            default: begin
              if (i != last) i <= i + CW'(1);
            end
          endcase
        end
        S_DONE: begin
          m_axis_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'(total), vidx, inside_r, status};

endmodule

FILE: design/pvt_mem.sv
module pvt_mem
  import pvt_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/tb.sv
module tb
  import pvt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  class result_board;
    logic [15:0] pending_q[$];
    int errors;
    bit signed [15:0] vx[64];
    bit signed [15:0] vy[64];
    int total;
    int cursor1;
    int radius;

    function new();
      errors = 0;
      total = 0;
      cursor1 = 0;
      radius = RADIUS_RESET;
    endfunction

    function int find_near(longint px, longint py);
      for (int i = 0; i < total; i++) begin
        if (vx[i] >= px - radius && vx[i] <= px + radius &&
            vy[i] >= py - radius && vy[i] <= py + radius) return i;
      end
      return -1;
    endfunction

    function int quad(longint ax, longint ay, longint px, longint py);
      return ((ax < px) ? 0 : 1) + ((ay >= py) ? 2 : 0);
    endfunction

    function bit crossing_parity(longint px, longint py);
      int hits;
      int j;
      int p1;
      int p2;
      longint d;
      longint lhs;
      longint rhs;
      hits = 0;
      for (int i = 0; i < total; i++) begin
        j = (i + 1 == total) ? 0 : i + 1;
        if (vy[i] == vy[j] && py == vy[i]) continue;
        p1 = quad(vx[i], vy[i], px, py);
        p2 = quad(vx[j], vy[j], px, py);
        if ((p1 == 0 && p2 == 3) || (p1 == 3 && p2 == 0) ||
            (p1 == 1 && p2 == 2) || (p1 == 2 && p2 == 1)) begin
          d = longint'(vy[j]) - vy[i];
          lhs = (py - vy[i]) * (longint'(vx[j]) - vx[i]);
          rhs = (px - vx[i]) * d;
          if ((d > 0 && lhs >= rhs) || (d < 0 && lhs <= rhs)) hits++;
        end
        if ((p1 == 1 && p2 == 3) || (p1 == 3 && p2 == 1)) hits++;
      end
      return hits[0];
    endfunction

    function void note_word(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y);
      logic [1:0] st;
      logic ins;
      logic [5:0] idx;
      int f;
      st = ST_OK;
      ins = 0;
      idx = 0;
      case (op)
        OP_INSERT: begin
          if (total >= 64) begin
            st = ST_FULL;
          end else begin
            f = (cursor1 > total) ? total : cursor1;
            for (int i = total; i > f; i--) begin
              vx[i] = vx[i-1];
              vy[i] = vy[i-1];
            end
            vx[f] = x;
            vy[f] = y;
            total++;
            cursor1 = f + 1;
            idx = 6'(f);
          end
        end
        OP_SELECT, OP_DELETE: begin
          f = find_near(x, y);
          if (f < 0) begin
            st = ST_MISS;
          end else begin
            idx = 6'(f);
            if (op == OP_SELECT) begin
              cursor1 = f + 1;
            end else begin
              for (int i = f; i + 1 < total; i++) begin
                vx[i] = vx[i+1];
                vy[i] = vy[i+1];
              end
              total--;
              if (f < cursor1) cursor1--;
            end
          end
        end
        OP_SHIFT: begin
          for (int i = 0; i < total; i++) begin
            vx[i] = vx[i] + x;
            vy[i] = vy[i] + y;
          end
        end
        OP_INSIDE: ins = crossing_parity(x, y);
        OP_CLEAR: begin
          total = 0;
          cursor1 = 0;
        end
        default: ;
      endcase
      pending_q.push_back({7'(total), idx, ins, st});
    endfunction

    function void check_word(logic [15:0] got);
      logic [15:0] want;
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got[1:0] !== want[1:0]) begin
        $error("status expected %0d actual %0d", want[1:0], got[1:0]);
        errors++;
      end
      if (got[2] !== want[2]) begin
        $error("inside_res expected %0d actual %0d", want[2], got[2]);
        errors++;
      end
      if (got[8:3] !== want[8:3]) begin
        $error("vertex_index expected %0d actual %0d", want[8:3], got[8:3]);
        errors++;
      end
      if (got[15:9] !== want[15:9]) begin
        $error("vertex_count expected %0d actual %0d", want[15:9], got[15:9]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = 0;  // operation[2:0], x[18:3], y[34:19]
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;      // status[1:0], inside_res[2], vertex_index[8:3], vertex_count[15:9]
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  result_board board = new();
  int hold_off = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  polygon_vertex_table_inside_test_top i_dut (.*);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_radius(int r);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_PICK_RADIUS;
    pwdata <= r;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.radius = r;
  endtask

  task automatic send_word(logic [2:0] op, logic [15:0] x, logic [15:0] y, bit keep);
    s_axis_tvalid = 1;
    s_axis_tdata <= {5'd0, y, x, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_word(op, x, y);
    @(negedge clk);
    if (!keep) s_axis_tvalid = 0;
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_random(int n, int spread);
    int burst;
    logic [2:0] op;
    logic [15:0] x;
    logic [15:0] y;
    int k;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        s_axis_tvalid = 0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      k = $urandom_range(0, 99);
      if (k < 40) op = OP_INSERT;
      else if (k < 52) op = OP_SELECT;
      else if (k < 64) op = OP_DELETE;
      else if (k < 70) op = OP_SHIFT;
      else if (k < 94) op = OP_INSIDE;
      else if (k < 97) op = OP_CLEAR;
      else op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
      if (spread == 0 || (op == OP_SELECT || op == OP_DELETE) && board.total > 0 &&
          $urandom_range(0, 1)) begin
        if (board.total > 0 && op != OP_SHIFT && op != OP_INSERT) begin
          k = $urandom_range(0, board.total - 1);
          x = board.vx[k] + $signed(8'($urandom_range(0, 40) - 20));
          y = board.vy[k] + $signed(8'($urandom_range(0, 40) - 20));
        end else begin
          x = 16'($signed(12'($urandom)));
          y = 16'($signed(12'($urandom)));
        end
        if (op == OP_SHIFT) begin
          x = 16'($signed(6'($urandom)));
          y = 16'($signed(6'($urandom)));
        end
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      send_word(op, x, y, burst != 0 && i != n - 1);
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_word(OP_INSIDE, 0, 0, 0);
    send_word(OP_SELECT, 0, 0, 0);
    send_word(OP_INSERT, 16'h8000, 16'h8000, 0);
    send_word(OP_INSIDE, 0, 0, 0);
    send_word(OP_INSERT, 16'h7fff, 16'h8000, 0);
    send_word(OP_INSERT, 16'h7fff, 16'h7fff, 0);
    send_word(OP_INSERT, 16'h0000, 16'h7fff, 0);
    send_word(OP_INSIDE, 0, 0, 0);
    send_word(OP_INSIDE, 100, 16'h7fff, 0);
    send_word(OP_INSIDE, 16'h7fff, 0, 0);
    send_word(OP_SHIFT, 16'h7fff, 1, 0);
    send_word(OP_INSIDE, 16'hffff, 16'hffff, 0);
    send_word(OP_SELECT, 16'h7ffe, 16'h8001, 0);
    send_word(OP_INSERT, 5, 5, 0);
    send_word(OP_DELETE, 16'h7ff0, 16'h7ff0, 0);
    send_word(OP_DELETE, 16'h8000, 16'h8001, 0);
    send_word(OP_DELETE, 16'hffff, 16'h8001, 0);
    send_word(OP_SPARE6, 1, 1, 0);
    send_word(OP_SPARE7, 16'hffff, 16'hffff, 0);
    send_word(OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < 65; i++) send_word(OP_INSERT, 16'(i * 300), 16'((i % 7) * 900), 1);
    send_word(OP_INSIDE, 3000, 2000, 0);
    drain();
    write_radius(0);
    stall_mode = 1;
    send_random(350, 0);
    write_radius(255);
    stall_mode = 2;
    send_random(350, 1);
    fork
      hold_off = 3000;
      send_random(40, 0);
    join
    write_radius($urandom_range(1, 254));
    stall_mode = 0;
    send_random(350, 0);
    write_radius(10);
    stall_mode = 1;
    send_random(300, 1);
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
